// File: rtl/core/xmd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xmd_pkg
// Shared types and codes of the integer multiply / divide unit.
// ---------------------------------------------------------------------------
package xmd_pkg;

  localparam int WB_W = 7;  // holds an operand width of up to 64 bits

  typedef enum logic [2:0] {
    OP_MUL    = 3'd0,
    OP_IMUL_W = 3'd1,
    OP_IMUL_T = 3'd2,
    OP_DIV    = 3'd3,
    OP_IDIV   = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  width_sel;
    logic [63:0] a_low;
    logic [63:0] a_high;
    logic [63:0] b_operand;
    logic        b_is_imm8;
  } cmd_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic        carry_flag;
    logic        overflow_flag;
    logic        sign_flag;
    logic        divide_error;
  } res_t;

  // control word that rides along the cell chain
  typedef struct packed {
    logic            valid;
    logic [2:0]      op;
    logic [WB_W-1:0] wb;       // operand width in bits
    logic            neg_lo;   // negate product / quotient at the end
    logic            neg_hi;   // negate remainder at the end
    logic            pre_err;  // divide error known before the chain
  } ctl_t;

endpackage

// File: rtl/core/xmd_prep.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xmd_prep
// Operand decode: width mask, immediate extension, magnitudes, early checks.
// ---------------------------------------------------------------------------
module xmd_prep #(
  parameter int W = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  xmd_pkg::cmd_t   cmd,
  output xmd_pkg::ctl_t   ctl,
  output logic [2*W-1:0]  acc,
  output logic [W-1:0]    opnd,
  output logic [W-1:0]    mplr
);
  import xmd_pkg::*;

  localparam int DW = 2 * W;
  localparam logic [W-1:0]  ONES  = {W{1'b1}};
  localparam logic [DW-1:0] DONES = {DW{1'b1}};
  localparam logic [WB_W-1:0] WMAX = WB_W'(W);

  logic [WB_W-1:0] wb_raw, wb;
  logic [W-1:0]    m, x, xh, y, imm, ax, ay, dm, sx, sy, sh;
  logic [DW-1:0]   m2, v2, mag;
  logic            xneg, yneg, hneg, err;
  ctl_t            ctl_next;
  logic [DW-1:0]   acc_next;
  logic [W-1:0]    opnd_next, mplr_next;

  always_comb begin
    wb_raw = WB_W'(8) << cmd.width_sel;
    wb     = (wb_raw > WMAX) ? WMAX : wb_raw;
    m      = ONES >> (WMAX - wb);
    m2     = DONES >> (DW - 2 * int'(wb));
    x      = cmd.a_low[W-1:0] & m;
    xh     = cmd.a_high[W-1:0] & m;
    imm    = W'($signed(cmd.b_operand[7:0]));
    y      = (cmd.b_is_imm8 ? imm : cmd.b_operand[W-1:0]) & m;
    sx     = x >> (wb - WB_W'(1));
    sy     = y >> (wb - WB_W'(1));
    sh     = xh >> (wb - WB_W'(1));
    xneg   = sx[0];
    yneg   = sy[0];
    hneg   = sh[0];
    ax     = xneg ? ((~x + W'(1)) & m) : x;
    ay     = yneg ? ((~y + W'(1)) & m) : y;
    dm     = ay;
    v2     = ({{W{1'b0}}, xh} << wb) | {{W{1'b0}}, x};
    mag    = hneg ? ((~v2 + DW'(1)) & m2) : v2;

    ctl_next         = '0;
    ctl_next.valid   = take;
    ctl_next.op      = cmd.op;
    ctl_next.wb      = wb;
    acc_next         = '0;
    opnd_next        = '0;
    mplr_next        = '0;
    err              = 1'b0;
    unique case (cmd.op)
      OP_MUL: begin
        opnd_next = x;
        mplr_next = y;
      end
      OP_IMUL_W, OP_IMUL_T: begin
        opnd_next       = ax;
        mplr_next       = ay;
        ctl_next.neg_lo = xneg ^ yneg;
      end
      OP_DIV: begin
        acc_next  = v2;
        opnd_next = y;
        err       = (y == '0) || (xh >= y);
      end
      OP_IDIV: begin
        acc_next        = mag;
        opnd_next       = dm;
        ctl_next.neg_lo = hneg ^ yneg;
        ctl_next.neg_hi = hneg;
        err             = (dm == '0) || (W'(mag >> wb) >= dm);
      end
      default: ;
    endcase
    ctl_next.pre_err = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_next;
    end
    acc  <= acc_next;
    opnd <= opnd_next;
    mplr <= mplr_next;
  end

endmodule

// File: rtl/core/xmd_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xmd_cell
// One step of the chain: a shift-add multiply step or a restoring divide step.
// ---------------------------------------------------------------------------
module xmd_cell #(
  parameter int W = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  xmd_pkg::ctl_t   ctl_in,
  input  logic [2*W-1:0]  acc_in,
  input  logic [W-1:0]    opnd_in,
  input  logic [W-1:0]    mplr_in,
  output xmd_pkg::ctl_t   ctl,
  output logic [2*W-1:0]  acc,
  output logic [W-1:0]    opnd,
  output logic [W-1:0]    mplr
);
  import xmd_pkg::*;

  localparam int DW = 2 * W;

  logic [DW:0]    sh;
  logic [W:0]     top, dif;
  logic           qbit;
  logic [DW-1:0]  acc_next;

  always_comb begin
    sh   = {acc_in, 1'b0};
    top  = sh[DW:W];
    dif  = top - {1'b0, opnd_in};
    qbit = (top >= {1'b0, opnd_in});
    if (ctl_in.op == OP_DIV || ctl_in.op == OP_IDIV) begin
      acc_next = {(qbit ? dif[W-1:0] : top[W-1:0]), sh[W-1:1], qbit};
    end else begin
      acc_next = sh[DW-1:0] + (mplr_in[W-1] ? {{W{1'b0}}, opnd_in} : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_in;
    end
    acc  <= acc_next;
    opnd <= opnd_in;
    mplr <= mplr_in << 1;
  end

endmodule

// File: rtl/core/xmd_post.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xmd_post
// Result fix-up: sign restore, width masking, flags and late divide checks.
// ---------------------------------------------------------------------------
module xmd_post #(
  parameter int W = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  xmd_pkg::ctl_t   ctl,
  input  logic [2*W-1:0]  acc,
  output logic            strobe,
  output xmd_pkg::res_t   result
);
  import xmd_pkg::*;

  localparam int DW = 2 * W;
  localparam logic [W-1:0]  ONES  = {W{1'b1}};
  localparam logic [DW-1:0] DONES = {DW{1'b1}};
  localparam logic [WB_W-1:0] WMAX = WB_W'(W);

  logic [W-1:0]  m, qm, rm, lim, rl, rh, sv;
  logic [DW-1:0] m2, p, up, upones;
  logic          cf, sf, de;
  res_t          res_next;

  always_comb begin
    m      = ONES >> (WMAX - ctl.wb);
    m2     = DONES >> (DW - 2 * int'(ctl.wb));
    p      = (ctl.neg_lo ? (~acc + DW'(1)) : acc) & m2;
    up     = p >> (ctl.wb - WB_W'(1));
    upones = m2 >> (ctl.wb - WB_W'(1));
    qm     = acc[W-1:0];
    rm     = acc[DW-1:W];
    lim    = W'(1) << (ctl.wb - WB_W'(1));
    rl     = '0;
    rh     = '0;
    sv     = '0;
    cf     = 1'b0;
    sf     = 1'b0;
    de     = 1'b0;
    unique case (ctl.op)
      OP_MUL: begin
        rl = p[W-1:0] & m;
        rh = W'(p >> ctl.wb) & m;
        cf = (rh != '0);
      end
      OP_IMUL_W, OP_IMUL_T: begin
        rl = p[W-1:0] & m;
        rh = (ctl.op == OP_IMUL_W) ? (W'(p >> ctl.wb) & m) : '0;
        cf = !(up == '0 || up == upones);
        sv = rl >> (ctl.wb - WB_W'(1));
        sf = sv[0];
      end
      OP_DIV: begin
        de = ctl.pre_err;
        rl = qm & m;
        rh = rm & m;
      end
      OP_IDIV: begin
        de = ctl.pre_err || (ctl.neg_lo ? (qm > lim) : (qm >= lim));
        rl = (ctl.neg_lo ? (~qm + W'(1)) : qm) & m;
        rh = (ctl.neg_hi ? (~rm + W'(1)) : rm) & m;
      end
      default: ;
    endcase
    if (de) begin
      rl = '0;
      rh = '0;
    end
    res_next               = '0;
    res_next.result_low    = 64'(rl);
    res_next.result_high   = 64'(rh);
    res_next.carry_flag    = cf;
    res_next.overflow_flag = cf;
    res_next.sign_flag     = sf;
    res_next.divide_error  = de;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.valid;
    end
    result <= res_next;
  end

endmodule

// File: rtl/core/x86_mul_div_unit_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// x86_mul_div_unit_top
// Pipelined x86 MUL / IMUL / DIV / IDIV execution unit.
// ---------------------------------------------------------------------------
// Takes one command word per clock and returns one result word per command,
// in order, after the command has passed through one
// decode stage, a chain of MAX_WIDTH cells that each retire one multiplier
// bit or one quotient bit, and one fix-up stage. busy never rises, so start
// may be held high every cycle. The result is shown for a single cycle with
// strobe high and cannot be held off; capture it on that edge or lose it.
// Divide by zero and quotient overflow return divide_error with zero results
// and flags. Operand widths above MAX_WIDTH are clamped to MAX_WIDTH.
// ---------------------------------------------------------------------------
module x86_mul_div_unit_top #(
  parameter int MAX_WIDTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  xmd_pkg::cmd_t cmd,
  output logic          strobe,
  output xmd_pkg::res_t result
);
  import xmd_pkg::*;

  localparam int W   = MAX_WIDTH;
  localparam int LAT = MAX_WIDTH + 2;

  // chain taps: index 0 is the decode stage output, index W the last cell
  ctl_t           ctl  [W+1];
  logic [2*W-1:0] acc  [W+1];
  logic [W-1:0]   opnd [W+1];
  logic [W-1:0]   mplr [W+1];

  // the pipeline never stalls, so a new word is taken every cycle
  assign busy = 1'b0;

  xmd_prep #(.W(W)) u_prep (
    .clk  (clk),
    .rst  (rst),
    .take (start && !busy),
    .cmd  (cmd),
    .ctl  (ctl[0]),
    .acc  (acc[0]),
    .opnd (opnd[0]),
    .mplr (mplr[0])
  );

  // each cell advances one bit of multiplier or dividend per cycle
  for (genvar i = 0; i < W; i++) begin : g_cell
    xmd_cell #(.W(W)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl[i]),
      .acc_in  (acc[i]),
      .opnd_in (opnd[i]),
      .mplr_in (mplr[i]),
      .ctl     (ctl[i+1]),
      .acc     (acc[i+1]),
      .opnd    (opnd[i+1]),
      .mplr    (mplr[i+1])
    );
  end

  xmd_post #(.W(W)) u_post (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl[W]),
    .acc    (acc[W]),
    .strobe (strobe),
    .result (result)
  );

  // every result word traces back to a command taken earlier
  a_strobe_origin : assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start, LAT))
    else $error("result strobe without a matching command");

  // a divide error zeroes both result halves and the flags
  a_err_zero : assert property (@(posedge clk) disable iff (rst)
    (strobe && result.divide_error) |->
      (result.result_low == '0 && result.result_high == '0 &&
       !result.carry_flag && !result.sign_flag))
    else $error("divide error with nonzero result");

  // CF and OF always travel together
  a_cf_of : assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.carry_flag == result.overflow_flag))
    else $error("carry and overflow flags disagree");

endmodule
